### rtl/interpolated_efficiency_acceptance_defines.svh
// Assertion macros used by the checker of this block.
`ifndef INTERPOLATED_EFFICIENCY_ACCEPTANCE_DEFINES_SVH
`define INTERPOLATED_EFFICIENCY_ACCEPTANCE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IEA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define IEA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/iea_pkg.sv
`default_nettype none

package iea_pkg;

  localparam int TABLE_POINTS_DEF = 64;

  localparam int WL_W      = 16;
  localparam int EFF_W     = 17;
  localparam int DRAW_W    = 16;
  localparam int IDX_W     = 6;
  localparam int PTS_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 7;
  localparam int NUM_W     = WL_W + EFF_W;
  localparam int ENTRY_W   = WL_W + EFF_W;

  localparam logic [EFF_W-1:0] EFF_ONE = 17'h10000;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_IN_USE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EFFICIENCY_ENABLE = 1'd1;

  typedef enum logic [2:0] {
    ST_IN_RANGE     = 3'd0,
    ST_OUT_OF_RANGE = 3'd1,
    ST_EMPTY        = 3'd2,
    ST_DISABLED     = 3'd3,
    ST_LOADED       = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SCAN,
    S_MUL,
    S_DSTART,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic              cmd;
    logic [IDX_W-1:0]  point_index;
    logic [WL_W-1:0]   wavelength;
    logic [EFF_W-1:0]  point_efficiency;
    logic [DRAW_W-1:0] uniform_draw;
  } item_t;

  typedef struct packed {
    logic             detected;
    logic [2:0]       status;
    logic [EFF_W-1:0] efficiency_out;
  } result_t;

  typedef struct packed {
    logic             done;
    logic [EFF_W-1:0] quot;
    logic             rem_nz;
  } div_res_t;

endpackage

`default_nettype wire

### rtl/iea_stream_if.sv
`default_nettype none

interface iea_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/interpolated_efficiency_acceptance.sv
// One transaction at a time; the table read port (one point per cycle) and the
// 17-step divider set the pace of a query.
// Reset: synchronous; clears control and points in use, enables efficiency;
// the table stays unknown.
`default_nettype none

module interpolated_efficiency_acceptance #(
  parameter int TABLE_POINTS = iea_pkg::TABLE_POINTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [iea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [iea_pkg::CFG_DAT_W-1:0] cfg_data,
  iea_stream_if.sink                         item,
  iea_stream_if.source                       result
);

  localparam int AW    = $clog2(TABLE_POINTS);
  localparam int NW    = $clog2(TABLE_POINTS + 1);
  localparam int WL_W  = iea_pkg::WL_W;
  localparam int EFF_W = iea_pkg::EFF_W;

  iea_pkg::state_t  state, state_next;
  iea_pkg::status_t res_status;

  logic [iea_pkg::PTS_W-1:0]  points_in_use;
  logic                       efficiency_enable;

  logic [WL_W-1:0]            q_wl;
  logic [iea_pkg::DRAW_W-1:0] q_draw;
  logic [AW-1:0]              last_idx;
  logic [AW-1:0]              cnt;
  logic [WL_W-1:0]            prev_w;
  logic [EFF_W-1:0]           prev_e;
  logic [WL_W-1:0]            dx;
  logic [WL_W-1:0]            dw;
  logic [EFF_W-1:0]           de;
  logic                       desc;
  logic [iea_pkg::NUM_W-1:0]  num;
  logic [EFF_W-1:0]           res_eff;

  logic                       out_valid;
  iea_pkg::result_t           out_data;

  logic                       accept;
  logic                       is_query;
  logic                       wr_en;
  logic [EFF_W-1:0]           wr_eff;
  logic [AW-1:0]              rd_addr;
  logic [iea_pkg::ENTRY_W-1:0] rdata;
  logic [WL_W-1:0]            rw;
  logic [EFF_W-1:0]           re;
  logic [NW-1:0]              n_sel;
  logic                       slot_free;
  logic                       div_start;
  iea_pkg::div_res_t          div_res;

  assign accept    = item.valid && item.ready;
  assign is_query  = item.data.cmd == iea_pkg::CMD_QUERY;
  assign slot_free = !out_valid || result.ready;
  assign rw        = rdata[iea_pkg::ENTRY_W-1:EFF_W];
  assign re        = rdata[EFF_W-1:0];
  assign wr_eff    = (item.data.point_efficiency > iea_pkg::EFF_ONE) ?
                     iea_pkg::EFF_ONE : item.data.point_efficiency;
  assign wr_en     = accept && !is_query &&
                     (32'(item.data.point_index) < TABLE_POINTS);
  assign n_sel     = (32'(points_in_use) > TABLE_POINTS) ?
                     NW'(TABLE_POINTS) : NW'(32'(points_in_use));

  assign item.ready   = state == iea_pkg::S_IDLE;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  iea_ram #(
    .WIDTH (iea_pkg::ENTRY_W),
    .DEPTH (TABLE_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(item.data.point_index)),
    .wdata ({item.data.wavelength, wr_eff}),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  iea_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (dw),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use     <= '0;
      efficiency_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        iea_pkg::CFG_POINTS_IN_USE:     points_in_use     <= cfg_data[iea_pkg::PTS_W-1:0];
        iea_pkg::CFG_EFFICIENCY_ENABLE: efficiency_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iea_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = '0;
    div_start  = 1'b0;
    unique case (state)
      iea_pkg::S_IDLE: begin
        if (accept) begin
          if (!is_query || !efficiency_enable || n_sel == '0) begin
            state_next = iea_pkg::S_EMIT;
          end else begin
            state_next = iea_pkg::S_FIRST;
          end
        end
      end
      iea_pkg::S_FIRST: begin
        rd_addr    = last_idx;
        state_next = (q_wl < rw) ? iea_pkg::S_EMIT : iea_pkg::S_LAST;
      end
      iea_pkg::S_LAST: begin
        state_next = (q_wl > rw) ? iea_pkg::S_EMIT : iea_pkg::S_SCAN;
      end
      iea_pkg::S_SCAN: begin
        rd_addr = AW'(cnt + 1'b1);
        if (rw == q_wl || (rw > q_wl && cnt == '0)) begin
          state_next = iea_pkg::S_EMIT;
        end else if (rw > q_wl) begin
          state_next = iea_pkg::S_MUL;
        end
      end
      iea_pkg::S_MUL: begin
        state_next = iea_pkg::S_DSTART;
      end
      iea_pkg::S_DSTART: begin
        div_start  = 1'b1;
        state_next = iea_pkg::S_DIV;
      end
      iea_pkg::S_DIV: begin
        if (div_res.done) begin
          state_next = iea_pkg::S_EMIT;
        end
      end
      iea_pkg::S_EMIT: begin
        if (slot_free) begin
          state_next = iea_pkg::S_IDLE;
        end
      end
      default: state_next = iea_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      iea_pkg::S_IDLE: begin
        if (accept) begin
          q_wl     <= item.data.wavelength;
          q_draw   <= item.data.uniform_draw;
          last_idx <= AW'(n_sel - 1'b1);
          res_eff  <= '0;
          if (!is_query) begin
            res_status <= iea_pkg::ST_LOADED;
          end else if (!efficiency_enable) begin
            res_status <= iea_pkg::ST_DISABLED;
          end else if (n_sel == '0) begin
            res_status <= iea_pkg::ST_EMPTY;
          end else begin
            res_status <= iea_pkg::ST_OUT_OF_RANGE;
          end
        end
      end
      iea_pkg::S_LAST: begin
        cnt <= '0;
      end
      iea_pkg::S_SCAN: begin
        if (rw == q_wl || (rw > q_wl && cnt == '0)) begin
          res_eff    <= re;
          res_status <= iea_pkg::ST_IN_RANGE;
        end else if (rw > q_wl) begin
          dx   <= q_wl - prev_w;
          dw   <= rw - prev_w;
          desc <= re < prev_e;
          de   <= (re < prev_e) ? prev_e - re : re - prev_e;
        end else begin
          prev_w <= rw;
          prev_e <= re;
          cnt    <= AW'(cnt + 1'b1);
        end
      end
      iea_pkg::S_MUL: begin
        num <= iea_pkg::NUM_W'(de) * iea_pkg::NUM_W'(dx);
      end
      iea_pkg::S_DIV: begin
        if (div_res.done) begin
          res_status <= iea_pkg::ST_IN_RANGE;
          res_eff    <= desc ? prev_e - div_res.quot - EFF_W'(div_res.rem_nz) :
                               prev_e + div_res.quot;
        end
      end
      iea_pkg::S_EMIT: begin
        if (slot_free) begin
          out_data.detected       <= {1'b0, q_draw} < res_eff;
          out_data.status         <= res_status;
          out_data.efficiency_out <= res_eff;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == iea_pkg::S_EMIT && slot_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/iea_ram.sv
`default_nettype none

module iea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/iea_div.sv
`default_nettype none

module iea_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [iea_pkg::NUM_W-1:0] num,
  input  wire logic [iea_pkg::WL_W-1:0]  den,
  output iea_pkg::div_res_t              res
);

  localparam int QW = iea_pkg::EFF_W;
  localparam int RW = iea_pkg::WL_W;

  logic [RW-1:0]         rem;
  logic [QW-1:0]         low;
  logic [QW-1:0]         quot;
  logic [$clog2(QW):0]   cnt;
  logic                  busy;
  logic                  done;
  logic [RW:0]           trial;
  logic                  fits;

  assign trial = {rem, low[QW-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= ($clog2(QW) + 1)'(QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num[iea_pkg::NUM_W-1:QW];
      low  <= num[QW-1:0];
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? RW'(trial - {1'b0, den}) : RW'(trial);
      low  <= {low[QW-2:0], 1'b0};
      quot <= {quot[QW-2:0], fits};
    end
  end

  assign res.done   = done;
  assign res.quot   = quot;
  assign res.rem_nz = rem != '0;

endmodule

`default_nettype wire

### rtl/iea_checker.sv
`default_nettype none

`include "interpolated_efficiency_acceptance_defines.svh"

module iea_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             valid,
  input wire logic             ready,
  input wire iea_pkg::result_t data
);

  `IEA_ASSERT_NEXT(a_hold, clk, rst, valid && !ready, valid && $stable(data), "result dropped")
  `IEA_ASSERT_IMPLY(a_zero, clk, rst, valid && data.status != iea_pkg::ST_IN_RANGE, data.efficiency_out == '0 && !data.detected, "nonzero efficiency outside range")
  `IEA_ASSERT_IMPLY(a_det, clk, rst, valid && data.detected, data.efficiency_out != '0, "detected with zero efficiency")
  `IEA_ASSERT_IMPLY(a_max, clk, rst, valid, data.efficiency_out <= iea_pkg::EFF_ONE, "efficiency above one")

endmodule

bind interpolated_efficiency_acceptance iea_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .valid (result.valid),
  .ready (result.ready),
  .data  (result.data)
);

`default_nettype wire

### dv/interpolated_efficiency_acceptance_test.sv
`default_nettype none

module interpolated_efficiency_acceptance_test;
  import iea_pkg::*;

  localparam int POINTS = TABLE_POINTS_DEF;
  localparam int HOLDOFF_CYCLES = 400;

  typedef struct {
    bit      typed;
    result_t want;
  } note_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DAT_W-1:0] reg_val;
    item_t                it;
    bit                   typed;
    result_t              want;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  iea_stream_if #(.payload_t(item_t))   item_if ();
  iea_stream_if #(.payload_t(result_t)) result_if ();

  interpolated_efficiency_acceptance i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_if),
    .result    (result_if)
  );

  // Mirror of the block state
  logic [WL_W-1:0]  wl_tab  [POINTS];
  logic [EFF_W-1:0] eff_tab [POINTS];
  logic [PTS_W-1:0] pts_cfg = 7'd0;
  logic             en_cfg = 1'b1;

  result_t acceptance_q [$];
  note_t   note_q [$];
  row_t    rows [$];
  int      items_sent = 0;
  int      results_seen = 0;
  int      errors = 0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  bit      holdoff_kick = 1'b0;
  bit      seen_kick = 1'b0;
  int      hold_left = 0;

  always #5 clk = ~clk;

  function automatic result_t predict_acceptance(item_t it);
    result_t           r;
    int unsigned       n;
    int unsigned       u;
    bit                done;
    logic [EFF_W-1:0]  eff;
    longint unsigned   dx;
    longint unsigned   dw;
    longint unsigned   e0;
    longint unsigned   e1;
    r = '0;
    if (it.cmd == CMD_LOAD) begin
      wl_tab[it.point_index] = it.wavelength;
      eff_tab[it.point_index] = (it.point_efficiency > EFF_ONE) ? EFF_ONE : it.point_efficiency;
      r.status = ST_LOADED;
      return r;
    end
    if (!en_cfg) begin
      r.status = ST_DISABLED;
      return r;
    end
    n = (pts_cfg > POINTS) ? POINTS : pts_cfg;
    if (n == 0) begin
      r.status = ST_EMPTY;
      return r;
    end
    if (it.wavelength < wl_tab[0] || it.wavelength > wl_tab[n-1]) begin
      r.status = ST_OUT_OF_RANGE;
      return r;
    end
    eff = '0;
    done = 1'b0;
    for (u = 0; u < n && !done; u++) begin
      if (wl_tab[u] == it.wavelength) begin
        eff = eff_tab[u];
        done = 1'b1;
      end else if (wl_tab[u] > it.wavelength) begin
        if (u == 0) begin
          eff = eff_tab[0];
        end else begin
          dx = it.wavelength - wl_tab[u-1];
          dw = wl_tab[u] - wl_tab[u-1];
          e0 = eff_tab[u-1];
          e1 = eff_tab[u];
          if (e1 >= e0) eff = e0 + ((e1 - e0) * dx) / dw;
          else eff = e0 - ((e0 - e1) * dx + dw - 1) / dw;
        end
        done = 1'b1;
      end
    end
    r.detected = (it.uniform_draw < eff);
    r.status = ST_IN_RANGE;
    r.efficiency_out = eff;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic row_t item_row(logic cmd, logic [IDX_W-1:0] idx, logic [WL_W-1:0] wl,
                                    logic [EFF_W-1:0] pe, logic [DRAW_W-1:0] draw, bit typed,
                                    status_t st, logic det, logic [EFF_W-1:0] eff);
    row_t r;
    r = '{default: '0};
    r.it.cmd = cmd;
    r.it.point_index = idx;
    r.it.wavelength = wl;
    r.it.point_efficiency = pe;
    r.it.uniform_draw = draw;
    r.typed = typed;
    r.want.detected = det;
    r.want.status = st;
    r.want.efficiency_out = eff;
    return r;
  endfunction

  function automatic void add_row(row_t r);
    rows.insert(rows.size(), r);
  endfunction

  task automatic send_item(item_t it, bit typed, result_t want);
    note_t n;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    n.typed = typed;
    n.want = want;
    note_q.insert(note_q.size(), n);
    item_if.valid <= 1'b1;
    item_if.data <= it;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic settle_block();
    item_if.valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_POINTS_IN_USE) pts_cfg = val;
    else en_cfg = val[0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_ascending_table(int max_step);
    item_t   it;
    int      wl;
    result_t none;
    none = '0;
    wl = $urandom_range(0, 2000);
    for (int u = 0; u < POINTS; u++) begin
      it = '0;
      it.cmd = CMD_LOAD;
      it.point_index = u;
      it.wavelength = wl;
      it.point_efficiency = ($urandom_range(7) == 0) ? $urandom_range(131071)
                                                     : $urandom_range(65536);
      it.uniform_draw = $urandom_range(65535);
      send_item(it, 1'b0, none);
      wl += $urandom_range(1, max_step);
    end
  endtask

  always @(posedge clk) begin
    if (holdoff_kick != seen_kick) begin
      seen_kick = holdoff_kick;
      hold_left = HOLDOFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    note_t   n;
    if (!rst) begin
      if (result_if.valid && result_if.ready) begin
        results_seen++;
        got = result_if.data;
        if (acceptance_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction, expected none, got status %0d", $time,
                   got.status);
        end else begin
          want = acceptance_q.pop_front();
          if (got.detected !== want.detected) begin
            errors++;
            $display("%0t: detected expected %0d, got %0d", $time, want.detected,
                     got.detected);
          end
          if (got.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
          end
          if (got.efficiency_out !== want.efficiency_out) begin
            errors++;
            $display("%0t: efficiency_out expected %0d, got %0d", $time,
                     want.efficiency_out, got.efficiency_out);
          end
        end
      end
      if (item_if.valid && item_if.ready) begin
        n = note_q.pop_front();
        got = predict_acceptance(item_if.data);
        acceptance_q.insert(acceptance_q.size(), n.typed ? n.want : got);
      end
    end
  end

  initial begin
    row_t    row;
    item_t   it;
    result_t none;
    int      idle_send [4];
    int      idle_stall [4];
    int      pts_set [8];
    int      n;
    int      r;
    none = '0;
    idle_send = '{0, 46, 0, 24};
    idle_stall = '{0, 0, 46, 24};
    pts_set = '{64, 127, 1, 2, -1, 0, -1, 64};

    item_if.valid <= 1'b0;
    item_if.data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    add_row(item_row(CMD_QUERY, 0, 1000, 0, 0, 1, ST_EMPTY, 0, 0));
    add_row(cfg_row(CFG_EFFICIENCY_ENABLE, 0));
    add_row(item_row(CMD_QUERY, 63, 0, 131071, 65535, 1, ST_DISABLED, 0, 0));
    add_row(cfg_row(CFG_EFFICIENCY_ENABLE, 1));
    add_row(item_row(CMD_LOAD, 0, 10, 0, 0, 1, ST_LOADED, 0, 0));
    add_row(item_row(CMD_LOAD, 1, 1000, 131071, 65535, 1, ST_LOADED, 0, 0));
    add_row(item_row(CMD_LOAD, 2, 3000, 20000, 0, 1, ST_LOADED, 0, 0));
    add_row(item_row(CMD_LOAD, 3, 65535, 65536, 0, 1, ST_LOADED, 0, 0));
    add_row(cfg_row(CFG_POINTS_IN_USE, 4));
    add_row(item_row(CMD_QUERY, 0, 0, 0, 0, 1, ST_OUT_OF_RANGE, 0, 0));
    add_row(item_row(CMD_QUERY, 0, 10, 0, 0, 1, ST_IN_RANGE, 0, 0));
    add_row(item_row(CMD_QUERY, 0, 1000, 0, 65535, 1, ST_IN_RANGE, 1, 65536));
    add_row(item_row(CMD_QUERY, 0, 65535, 0, 65535, 1, ST_IN_RANGE, 1, 65536));
    add_row(item_row(CMD_QUERY, 0, 500, 0, 32439, 0, ST_IN_RANGE, 0, 0));
    add_row(item_row(CMD_QUERY, 0, 500, 0, 32440, 0, ST_IN_RANGE, 0, 0));
    add_row(item_row(CMD_QUERY, 0, 2000, 0, 42768, 0, ST_IN_RANGE, 0, 0));
    add_row(item_row(CMD_QUERY, 0, 40000, 0, 30000, 0, ST_IN_RANGE, 0, 0));
    add_row(cfg_row(CFG_POINTS_IN_USE, 2));
    add_row(item_row(CMD_QUERY, 0, 1001, 0, 0, 1, ST_OUT_OF_RANGE, 0, 0));
    add_row(item_row(CMD_QUERY, 0, 999, 0, 65535, 0, ST_IN_RANGE, 0, 0));
    add_row(cfg_row(CFG_POINTS_IN_USE, 3));
    add_row(item_row(CMD_LOAD, 2, 800, 40000, 0, 1, ST_LOADED, 0, 0));
    add_row(item_row(CMD_QUERY, 0, 900, 0, 0, 1, ST_OUT_OF_RANGE, 0, 0));
    add_row(item_row(CMD_QUERY, 0, 700, 0, 20000, 0, ST_IN_RANGE, 0, 0));

    foreach (rows[i]) begin
      row = rows[i];
      if (row.is_cfg) begin
        settle_block();
        write_register(row.reg_idx, row.reg_val);
      end else begin
        send_item(row.it, row.typed, row.want);
      end
    end

    for (int phase = 0; phase < 8; phase++) begin
      settle_block();
      write_register(CFG_POINTS_IN_USE,
                     (pts_set[phase] < 0) ? $urandom_range(3, 63) : pts_set[phase]);
      write_register(CFG_EFFICIENCY_ENABLE, (phase == 6) ? 1'b0 : 1'b1);
      send_idle_pct = idle_send[phase % 4];
      stall_pct = idle_stall[phase % 4];
      if (phase == 0 || phase == 4) load_ascending_table(900);
      else if (phase == 7) load_ascending_table(3);
      for (int k = 0; k < 42; k++) begin
        // hold the receiver off while items keep coming
        if (phase == 0 && k == 5) holdoff_kick = ~holdoff_kick;
        n = (pts_cfg > POINTS) ? POINTS : pts_cfg;
        r = $urandom_range(99);
        it = '0;
        it.point_index = $urandom_range(63);
        it.uniform_draw = $urandom_range(65535);
        it.point_efficiency = ($urandom_range(3) == 0) ? $urandom_range(131071)
                                                       : $urandom_range(65536);
        if (r < 8) begin
          it.cmd = CMD_LOAD;
          it.wavelength = $urandom_range(65535);
        end else begin
          it.cmd = CMD_QUERY;
          if (n == 0 || r < 28) it.wavelength = $urandom_range(65535);
          else if (r < 40) it.wavelength = wl_tab[$urandom_range(n - 1)];
          else it.wavelength = $urandom_range(wl_tab[0], wl_tab[n-1]);
        end
        send_item(it, 1'b0, none);
      end
    end

    settle_block();
    repeat (100) @(posedge clk);
    if (acceptance_q.size() != 0) begin
      errors += acceptance_q.size();
      $display("%0t: %0d results expected, 0 got", $time, acceptance_q.size());
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

### interpolated_efficiency_acceptance.f
+incdir+rtl
rtl/iea_pkg.sv
rtl/iea_stream_if.sv
rtl/iea_ram.sv
rtl/iea_div.sv
rtl/interpolated_efficiency_acceptance.sv
rtl/iea_checker.sv
dv/interpolated_efficiency_acceptance_test.sv
